>>> rtl/core/base64_stream_decoder_assert.svh
// Assertion macros for the base64 stream decoder checker.
// Needs a clk and an active-low rst_n in the scope where a macro is used.
`ifndef BASE64_STREAM_DECODER_ASSERT_SVH
`define BASE64_STREAM_DECODER_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define B64D_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("b64d assertion failed");

// Next-cycle implication, disabled in reset.
`define B64D_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("b64d assertion failed");

`endif

>>> rtl/core/b64d_pkg.sv
// Package for the base64 stream decoder: result word type, character codes,
// alphabet lookup and byte assembly functions. No dependencies.
package b64d_pkg;

    localparam logic [7:0] CHAR_PAD     = 8'h3D;  // '='
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
    localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_SLASH   = 8'h2F;

    localparam logic [7:0] LOWER_BASE = 8'd26;
    localparam logic [7:0] DIGIT_BASE = 8'd52;
    localparam logic [5:0] SEXTET_PLUS  = 6'd62;
    localparam logic [5:0] SEXTET_SLASH = 6'd63;

    localparam logic [5:0] MASK_HI2 = 6'h30;
    localparam logic [5:0] MASK_LO4 = 6'h0F;
    localparam logic [5:0] MASK_MID = 6'h3C;
    localparam logic [5:0] MASK_LO2 = 6'h03;

    // One result word.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       run_last;
        logic       message_end;
    } result_t;

    // Bit 6 set: not an alphabet character.
    function automatic logic [6:0] sextet_of(input logic [7:0] c);
        logic [6:0] r;
        r = 7'h40;
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z)
            r = {1'b0, 6'(c - CHAR_UPPER_A)};
        else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z)
            r = {1'b0, 6'(c - CHAR_LOWER_A + LOWER_BASE)};
        else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9)
            r = {1'b0, 6'(c - CHAR_DIGIT_0 + DIGIT_BASE)};
        else if (c == CHAR_PLUS)
            r = {1'b0, SEXTET_PLUS};
        else if (c == CHAR_SLASH)
            r = {1'b0, SEXTET_SLASH};
        return r;
    endfunction

    function automatic logic [7:0] byte0(input logic [5:0] s0, input logic [5:0] s1);
        logic [5:0] hi;
        hi = s1 & MASK_HI2;
        return {s0, hi[5:4]};
    endfunction

    function automatic logic [7:0] byte1(input logic [5:0] s1, input logic [5:0] s2);
        logic [5:0] lo;
        logic [5:0] mid;
        lo  = s1 & MASK_LO4;
        mid = s2 & MASK_MID;
        return {lo[3:0], mid[5:2]};
    endfunction

    function automatic logic [7:0] byte2(input logic [5:0] s2, input logic [5:0] s3);
        logic [5:0] lo;
        lo = s2 & MASK_LO2;
        return {lo[1:0], s3};
    endfunction

endpackage

>>> rtl/core/base64_stream_decoder.sv
// Top level of the base64 stream decoder (standard alphabet).
// Depends on b64d_pkg and b64d_fifo.
//
// One character word enters per cycle. Alphabet characters become 6-bit
// sextets; anything else is skipped, and after the first '=' every character
// up to message_last is ignored. Each fourth sextet releases three bytes; on
// message_last a tail of two or three sextets releases one or two bytes, a
// lone sextet is dropped, and an end word with byte_valid low marks a final
// character that gave no byte. All decode state clears after message_last.
// An accepted character waits in the input register, where its results are
// formed and written into the result queue once it has room for three words;
// the head of the queue drives the output. The input takes a character every
// cycle while the queue has room for three words; the queue drains one byte
// per cycle, which at three bytes per four characters keeps one character
// per cycle sustained when out_ready stays high. QUEUE_DEPTH must be a
// power of two, at least 4; the block does not check it.
module base64_stream_decoder #(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] char_in,
    input  logic       message_last,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] data_byte,
    output logic       byte_valid,
    output logic       run_last,
    output logic       message_end
);

    // Input register.
    logic       stg_valid_reg, stg_valid_next;
    logic [7:0] stg_char_reg;
    logic       stg_last_reg;

    // Decode state.
    logic [5:0] sextet_store_reg [3];
    logic [5:0] sextet_store_next [3];
    logic [1:0] sextet_count_reg, sextet_count_next;
    logic       padding_seen_reg, padding_seen_next;

    logic [6:0] sx;
    logic       is_pad;
    logic       take;
    logic       group;
    logic [1:0] cnt_after;
    logic [5:0] st_a [3];
    logic [1:0] n_res;
    logic       advance;
    logic [1:0] push_n;
    logic       room;
    logic       pop;

    b64d_pkg::result_t slot [3];
    b64d_pkg::result_t head;

    // The register moves on when the queue can take a full group.
    assign advance  = stg_valid_reg && room;
    assign in_ready = !stg_valid_reg || room;
    assign push_n   = advance ? n_res : 2'd0;

    always_comb
    begin
        sx        = b64d_pkg::sextet_of(stg_char_reg);
        is_pad    = (stg_char_reg == b64d_pkg::CHAR_PAD);
        take      = !padding_seen_reg && !is_pad && !sx[6];
        group     = take && (sextet_count_reg == 2'd3);
        st_a      = sextet_store_reg;
        cnt_after = sextet_count_reg;
        if (take && !group)
        begin
            st_a[sextet_count_reg] = sx[5:0];
            cnt_after              = sextet_count_reg + 2'd1;
        end

        for (int k = 0; k < 3; k++)
            slot[k] = '0;
        n_res = 2'd0;

        if (group)
        begin
            // Fourth sextet completes the group: three bytes.
            slot[0].data_byte  = b64d_pkg::byte0(sextet_store_reg[0], sextet_store_reg[1]);
            slot[1].data_byte  = b64d_pkg::byte1(sextet_store_reg[1], sextet_store_reg[2]);
            slot[2].data_byte  = b64d_pkg::byte2(sextet_store_reg[2], sx[5:0]);
            slot[0].byte_valid = 1'b1;
            slot[1].byte_valid = 1'b1;
            slot[2].byte_valid = 1'b1;
            n_res              = 2'd3;
        end
        else if (stg_last_reg)
        begin
            // Tail flush; a bare end word when nothing is left.
            if (cnt_after >= 2'd2)
            begin
                slot[0].data_byte  = b64d_pkg::byte0(st_a[0], st_a[1]);
                slot[0].byte_valid = 1'b1;
                n_res              = 2'd1;
            end
            if (cnt_after == 2'd3)
            begin
                slot[1].data_byte  = b64d_pkg::byte1(st_a[1], st_a[2]);
                slot[1].byte_valid = 1'b1;
                n_res              = 2'd2;
            end
            if (n_res == 2'd0)
                n_res = 2'd1;
        end

        for (int k = 0; k < 3; k++)
        begin
            slot[k].run_last    = (n_res != 2'd0) && (2'(k) == n_res - 2'd1);
            slot[k].message_end = slot[k].run_last && stg_last_reg;
        end
    end

    always_comb
    begin
        stg_valid_next    = stg_valid_reg;
        sextet_store_next = sextet_store_reg;
        sextet_count_next = sextet_count_reg;
        padding_seen_next = padding_seen_reg;
        if (in_ready)
            stg_valid_next = in_valid;
        if (advance)
        begin
            if (stg_last_reg)
            begin
                for (int k = 0; k < 3; k++)
                    sextet_store_next[k] = '0;
                sextet_count_next = 2'd0;
                padding_seen_next = 1'b0;
            end
            else
            begin
                sextet_store_next = st_a;
                sextet_count_next = group ? 2'd0 : cnt_after;
                padding_seen_next = padding_seen_reg || is_pad;
            end
        end
    end

    // Payload of the input register.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            stg_char_reg <= char_in;
            stg_last_reg <= message_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg    <= 1'b0;
            for (int k = 0; k < 3; k++)
                sextet_store_reg[k] <= '0;
            sextet_count_reg <= 2'd0;
            padding_seen_reg <= 1'b0;
        end
        else
        begin
            stg_valid_reg    <= stg_valid_next;
            sextet_store_reg <= sextet_store_next;
            sextet_count_reg <= sextet_count_next;
            padding_seen_reg <= padding_seen_next;
        end
    end

    assign pop = out_valid && out_ready;

    b64d_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_n    (push_n),
        .push_data (slot),
        .pop       (pop),
        .head      (head),
        .not_empty (out_valid),
        .room      (room)
    );

    assign data_byte   = head.data_byte;
    assign byte_valid  = head.byte_valid;
    assign run_last    = head.run_last;
    assign message_end = head.message_end;

endmodule

>>> rtl/core/b64d_fifo.sv
// Result queue for the base64 stream decoder: takes up to three words per
// cycle, gives one per cycle while popped. Depends on b64d_pkg.
module b64d_fifo #(
    parameter int DEPTH = 8   // power of two, at least 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [1:0]           push_n,
    input  b64d_pkg::result_t    push_data [3],
    input  logic                 pop,
    output b64d_pkg::result_t    head,
    output logic                 not_empty,
    output logic                 room
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    b64d_pkg::result_t   mem_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]    count_reg, count_next;

    assign not_empty = (count_reg != '0);
    assign room      = (count_reg <= CNT_W'(DEPTH - 3));
    assign head      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push_n);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(push_n) - CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            if (2'(k) < push_n)
                mem_reg[wr_ptr_reg + PTR_W'(k)] <= push_data[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> rtl/core/b64d_checker.sv
// Port-level checker for the base64 stream decoder, bound to the top level.
// Depends on base64_stream_decoder_assert.svh.
`include "base64_stream_decoder_assert.svh"

module b64d_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [7:0] char_in,
    input logic       message_last,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] data_byte,
    input logic       byte_valid,
    input logic       run_last,
    input logic       message_end
);

    // A stalled result word holds.
    `B64D_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(data_byte) && $stable(byte_valid) && $stable(run_last) && $stable(message_end))

    // The message end closes its character's run.
    `B64D_ASSERT_NOW(a_end_is_run_last, out_valid && message_end, run_last)

    // A word without a byte is only the bare end marker.
    `B64D_ASSERT_NOW(a_bare_end, out_valid && !byte_valid, run_last && message_end && (data_byte == 8'd0))

    // Right after reset nothing is queued.
    `B64D_ASSERT_NOW(a_reset_empty, $rose(rst_n), !out_valid)

endmodule

bind base64_stream_decoder b64d_checker u_b64d_checker (.*);
